@@ rtl/core/dset_pkg.sv @@
// Shared types and constants for the date sorted event table.
package dset_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATE_W = 23;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_MODIFY = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_LIST_FWD = 3'd4;
    localparam logic [2:0] OP_LIST_REV = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [DATE_W-1:0] date;
        logic [15:0] seats;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input word, compute match and position
        logic remove;   // close the gap at the matched position
        logic insert;   // open a slot at the insert position and write
        logic read;     // load output register from list position
        logic [IDX_W-1:0] read_idx;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic [CNT_W-1:0] count;
    } dp_stat_t;

endpackage

@@ rtl/core/date_sorted_event_table_core.sv @@
// Top level of the date sorted event table.
// Each operation passes the execute state; a modify that hits also S_INS.
// Listing: from S_LIST on, one word per cycle while the consumer keeps up.
// Throughput: one operation at a time; the next word is taken once the
// result register is empty and the sequencer is idle.
// Reset (rst_n low, asynchronous) empties the table; entries are not cleared.
module date_sorted_event_table_core
    import dset_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] operation,
    input  logic [31:0] event_id,
    input  logic [4:0] day,
    input  logic [3:0] month,
    input  logic [13:0] year,
    input  logic [15:0] seat_count,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] status,
    output logic [31:0] found_id,
    output logic [4:0] found_day,
    output logic [3:0] found_month,
    output logic [13:0] found_year,
    output logic [15:0] found_seats,
    output logic last
);

    dp_cmd_t cmd;
    dp_stat_t stat;
    entry_t in_entry, rd_entry;
    logic report;

    // pack the date so a plain unsigned compare orders year, month, day
    assign in_entry.id = event_id;
    assign in_entry.date = {year, month, day};
    assign in_entry.seats = seat_count;

    dset_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(operation),
        .stat(stat), .cmd(cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .report(report), .last(last)
    );

    dset_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_entry(in_entry),
        .stat(stat), .rd_entry(rd_entry)
    );

    // zero the entry fields on words that report no entry
    assign found_id = report ? rd_entry.id : '0;
    assign found_day = report ? rd_entry.date[4:0] : '0;
    assign found_month = report ? rd_entry.date[8:5] : '0;
    assign found_year = report ? rd_entry.date[22:9] : '0;
    assign found_seats = report ? rd_entry.seats : '0;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (stat.count == CNT_W'(DEPTH)))
        else $error("full status with room left");

endmodule

@@ rtl/core/dset_datapath.sv @@
// Datapath: shift-register entry array with parallel id match and date compare.
module dset_datapath
    import dset_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  dp_cmd_t cmd,
    input  entry_t in_entry,
    output dp_stat_t stat,
    output entry_t rd_entry
);

    entry_t ent_reg [DEPTH];
    entry_t ent_next [DEPTH];
    entry_t cur_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic hit_reg;
    logic [IDX_W-1:0] mpos_reg;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] later;
    logic [DEPTH-1:0] mfirst;

    // first matching id inside the live region
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (ent_reg[i].id == in_entry.id) && (CNT_W'(i) < cnt_reg);
        end
        mfirst = match & ~(match - DEPTH'(1));
    end

    // later[i]: slot i unused or not before the new date (after removal shift)
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            later[i] = !(ent_reg[i].date < cur_reg.date) || (CNT_W'(i) >= cnt_reg);
        end
    end

    logic [IDX_W-1:0] menc;
    always_comb
    begin
        menc = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (mfirst[i])
            begin
                menc = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (cmd.remove && hit_reg)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (IDX_W'(i) >= mpos_reg)
                begin
                    ent_next[i] = ent_reg[i + 1];
                end
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (cmd.insert)
        begin
            // sorted: later is monotone, so shift every later slot up by one
            if (later[0])
            begin
                ent_next[0] = cur_reg;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (later[i])
                begin
                    if (!later[i - 1])
                    begin
                        ent_next[i] = cur_reg;
                    end
                    else
                    begin
                        ent_next[i] = ent_reg[i - 1];
                    end
                end
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.load)
            begin
                hit_reg <= |match;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        if (cmd.load)
        begin
            cur_reg <= in_entry;
            mpos_reg <= menc;
        end
        if (cmd.read)
        begin
            rd_entry <= ent_reg[cmd.read_idx];
        end
        else if (cmd.load)
        begin
            rd_entry <= ent_reg[menc];
        end
    end

    assign stat.hit = hit_reg;
    assign stat.count = cnt_reg;

endmodule

@@ rtl/core/dset_ctrl.sv @@
// Controller: operation sequencing and result handshake.
module dset_ctrl
    import dset_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] op,
    input  dp_stat_t stat,
    output dp_cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] status,
    output logic report,
    output logic last
);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_INS, S_LIST, S_OUT} state_t;

    state_t state_reg;
    logic [2:0] op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] left_reg;
    logic ov_reg, rep_reg, last_reg;
    logic [1:0] st_reg;
    logic take;

    assign take = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = take;
        cmd.read_idx = idx_reg;
        case (state_reg)
            S_EXEC:
            begin
                cmd.remove = (op_reg == OP_DELETE || op_reg == OP_MODIFY);
                cmd.insert = (op_reg == OP_INSERT) && (stat.count != CNT_W'(DEPTH));
            end
            S_INS:  cmd.insert = 1'b1;
            S_LIST: cmd.read = !ov_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            op_reg <= '0;
            idx_reg <= '0;
            left_reg <= '0;
            st_reg <= ST_OK;
            rep_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take && op <= OP_LIST_REV)
                    begin
                        op_reg <= op;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    ov_reg <= 1'b1;
                    rep_reg <= 1'b0;
                    last_reg <= 1'b1;
                    st_reg <= ST_OK;
                    case (op_reg)
                        OP_INSERT:
                            if (stat.count == CNT_W'(DEPTH)) st_reg <= ST_FULL;
                        OP_DELETE:
                            if (!stat.hit) st_reg <= ST_NOT_FOUND;
                        OP_MODIFY:
                        begin
                            if (!stat.hit) st_reg <= ST_NOT_FOUND;
                            else
                            begin
                                ov_reg <= 1'b0;
                                state_reg <= S_INS;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (!stat.hit) st_reg <= ST_NOT_FOUND;
                            rep_reg <= stat.hit;
                        end
                        default:
                        begin
                            if (stat.count == '0) st_reg <= ST_EMPTY;
                            else
                            begin
                                ov_reg <= 1'b0;
                                state_reg <= S_LIST;
                                left_reg <= stat.count;
                                idx_reg <= (op_reg == OP_LIST_FWD) ? '0
                                    : IDX_W'(stat.count - CNT_W'(1));
                            end
                        end
                    endcase
                end
                S_INS:
                begin
                    state_reg <= S_IDLE;
                    ov_reg <= 1'b1;
                end
                S_LIST:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1;
                        rep_reg <= 1'b1;
                        last_reg <= (left_reg == CNT_W'(1));
                        left_reg <= left_reg - CNT_W'(1);
                        idx_reg <= (op_reg == OP_LIST_FWD) ? idx_reg + IDX_W'(1)
                            : idx_reg - IDX_W'(1);
                        if (left_reg == CNT_W'(1))
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign report = rep_reg;
    assign last = last_reg;

endmodule
